### hw/rtl/lux_moving_average_threshold_macros.svh
// Assertion helpers used by the checker file.
// Each macro expects clock and reset to be visible in the calling scope.
`ifndef LUX_MOVING_AVERAGE_THRESHOLD_MACROS_SVH
`define LUX_MOVING_AVERAGE_THRESHOLD_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LUXMAT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LUXMAT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/luxmat_pkg.sv
package luxmat_pkg;

   localparam int SAMPLE_W              = 12;
   localparam int LUX_W                 = 17;
   // Magnitude width of the lux numerator 51200 - 50 * sample
   localparam int LUX_NUM_W             = 18;
   localparam int LUX_BASE              = 51200;
   localparam int LUX_SLOPE             = 50;
   localparam int LUX_SATURATED         = LUX_BASE - LUX_SLOPE;
   localparam int LUX_MIN               = -37;
   localparam int THRESHOLD_RESET       = 100;
   localparam int DEFAULT_WINDOW_LENGTH = 16;

endpackage

### hw/rtl/luxmat_div.sv
module luxmat_div #(
   parameter int NUM_W = luxmat_pkg::LUX_NUM_W,
   parameter int DEN_W = luxmat_pkg::SAMPLE_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             run_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quo_ff;
   logic [NUM_W-1:0] quo_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W+1:0] diff;
   logic             ge;

   // Restoring division, one quotient bit per cycle, MSB first
   always_comb begin
      rem_sh = {rem_ff, quo_ff[NUM_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, den_ff};
      ge     = ~diff[DEN_W+1];
      rem_in = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_in = {quo_ff[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(NUM_W);
            quo_ff <= num;
            rem_ff <= '0;
            den_ff <= den;
         end else if (run_ff) begin
            quo_ff <= quo_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

### hw/rtl/lux_moving_average_threshold.sv
// Light-sensor lux filter. Each accepted sample s is turned into
// lux = (51200 - 50*s) / s truncated toward zero (a zero sample saturates to
// 51150 and raises zero_sample), stored into a ring of WINDOW_LENGTH entries
// that replaces the oldest one, and the running window sum gives the reported
// average (sum / WINDOW_LENGTH, truncated toward zero) and the LED, which is
// on when the sum exceeds light_threshold * WINDOW_LENGTH. Entries not yet
// written count as zero from reset on, with no clearing pass. One sample is
// worked on at a time, in these steps: the bit-serial lux divider, then
// the ring write and sum update, then the average and LED, and last the load
// of the result register. The average is a reciprocal multiplication by the
// constant window length. The result register lets the next sample be
// accepted while a result still waits on rsp_stall. light_threshold is to be
// written through the csr port only while the block is idle; the block
// itself does not enforce this.
module lux_moving_average_threshold #(
   parameter int WINDOW_LENGTH = luxmat_pkg::DEFAULT_WINDOW_LENGTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic        [luxmat_pkg::SAMPLE_W-1:0] req_sensor_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [luxmat_pkg::LUX_W-1:0]    rsp_lux_value,
   output logic signed [luxmat_pkg::LUX_W-1:0]    rsp_window_average,
   output logic                                   rsp_led_on,
   output logic                                   rsp_zero_sample,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic signed [luxmat_pkg::LUX_W-1:0]    csr_light_threshold
);

   import luxmat_pkg::*;

   localparam int SLOT_W  = $clog2(WINDOW_LENGTH);
   localparam int SUM_W   = LUX_W + $clog2(WINDOW_LENGTH);
   localparam int WL_W    = $clog2(WINDOW_LENGTH + 1);
   localparam int THR_W   = LUX_W + WL_W;
   localparam int AVG_SH  = SUM_W + SLOT_W;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   // ceil(2^AVG_SH / WINDOW_LENGTH) gives the exact floor for any SUM_W-bit sum
   localparam longint AVG_RECIP_L =
      ((longint'(1) << AVG_SH) + longint'(WINDOW_LENGTH) - longint'(1)) /
      longint'(WINDOW_LENGTH);
   localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(AVG_RECIP_L);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LENGTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LUX,
      ST_SUM,
      ST_OUT
   } state_type;

   state_type                 state_ff;

   logic signed [LUX_W-1:0]   ring [WINDOW_LENGTH];
   logic signed [LUX_W-1:0]   rd_data_ff;
   logic [WINDOW_LENGTH-1:0]  fill_ff;
   logic                      old_vld_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [THR_W-1:0]   thr_scaled_ff;
   logic signed [THR_W-1:0]   thr_scaled_in;
   logic signed [THR_W-1:0]   csr_thr_ext;
   logic signed [THR_W-1:0]   wl_const;
   logic signed [THR_W-1:0]   sum_ext;

   logic                      zero_ff;
   logic                      lux_neg_ff;
   logic                      led_ff;
   logic signed [LUX_W-1:0]   lux_ff;
   logic signed [LUX_W-1:0]   avg_ff;

   logic                      rsp_valid_ff;
   logic signed [LUX_W-1:0]   rsp_lux_ff;
   logic signed [LUX_W-1:0]   rsp_avg_ff;
   logic                      rsp_led_ff;
   logic                      rsp_zero_ff;

   logic                      req_accept;
   logic                      is_zero;
   logic [SAMPLE_W-1:0]       s_eff;
   logic [LUX_NUM_W:0]        lux_prod;
   logic signed [LUX_NUM_W:0] lux_num;
   logic [LUX_NUM_W-1:0]      lux_mag;
   logic [SUM_W-1:0]          sum_mag;
   logic [PROD_W-1:0]         avg_prod;
   logic signed [LUX_W-1:0]   avg_mag;
   logic signed [LUX_W-1:0]   old_lux;
   logic signed [LUX_W-1:0]   quo_lo;
   logic signed [LUX_W-1:0]   lux_res;
   logic signed [LUX_W-1:0]   avg_res;

   logic                      div_done;
   logic [LUX_NUM_W-1:0]      div_quo;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // Lux numerator; a zero sample divides as a sample of one
   always_comb begin
      is_zero  = (req_sensor_sample == '0);
      s_eff    = is_zero ? SAMPLE_W'(1) : req_sensor_sample;
      lux_prod = (LUX_NUM_W + 1)'(s_eff) * (LUX_NUM_W + 1)'(LUX_SLOPE);
      lux_num  = $signed((LUX_NUM_W + 1)'(LUX_BASE)) - $signed(lux_prod);
      lux_mag  = lux_num[LUX_NUM_W] ? LUX_NUM_W'(-lux_num) : LUX_NUM_W'(lux_num);
      sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   end

   luxmat_div #(
      .NUM_W (LUX_NUM_W),
      .DEN_W (SAMPLE_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .num   (lux_mag),
      .den   (s_eff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      quo_lo   = $signed(div_quo[LUX_W-1:0]);
      lux_res  = lux_neg_ff ? -quo_lo : quo_lo;
      avg_prod = PROD_W'(sum_mag) * PROD_W'(AVG_RECIP);
      avg_mag  = $signed(avg_prod[AVG_SH +: LUX_W]);
      avg_res  = sum_ff[SUM_W-1] ? -avg_mag : avg_mag;
      // Entries never written read as zero
      old_lux  = old_vld_ff ? rd_data_ff : '0;
      sum_in   = sum_ff - SUM_W'(old_lux) + SUM_W'(lux_res);
      sum_ext  = THR_W'(sum_ff);
   end

   always_comb begin
      csr_thr_ext   = THR_W'(csr_light_threshold);
      wl_const      = THR_W'(WINDOW_LENGTH);
      thr_scaled_in = csr_thr_ext * wl_const;
   end

   // Ring storage: one read at acceptance, one write once the lux is known
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= ring[slot_ff];
      end
      if (state_ff == ST_LUX && div_done) begin
         ring[slot_ff] <= lux_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_scaled_ff <= THR_W'(THRESHOLD_RESET * WINDOW_LENGTH);
      end else if (csr_valid && csr_ready) begin
         thr_scaled_ff <= thr_scaled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         slot_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  zero_ff    <= is_zero;
                  lux_neg_ff <= lux_num[LUX_NUM_W];
                  old_vld_ff <= fill_ff[slot_ff];
                  state_ff   <= ST_LUX;
               end
            end
            ST_LUX: begin
               if (div_done) begin
                  lux_ff           <= lux_res;
                  sum_ff           <= sum_in;
                  fill_ff[slot_ff] <= 1'b1;
                  slot_ff          <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
                  state_ff         <= ST_SUM;
               end
            end
            ST_SUM: begin
               avg_ff   <= avg_res;
               led_ff   <= (sum_ext > thr_scaled_ff);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               // Hold until the result register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_lux_ff  <= lux_ff;
                  rsp_avg_ff  <= avg_ff;
                  rsp_led_ff  <= led_ff;
                  rsp_zero_ff <= zero_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_lux_value      = rsp_lux_ff;
   assign rsp_window_average = rsp_avg_ff;
   assign rsp_led_on         = rsp_led_ff;
   assign rsp_zero_sample    = rsp_zero_ff;

endmodule

### hw/rtl/luxmat_checker.sv
`include "lux_moving_average_threshold_macros.svh"

module luxmat_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [luxmat_pkg::LUX_W-1:0]    rsp_lux_value,
   input logic signed [luxmat_pkg::LUX_W-1:0]    rsp_window_average,
   input logic                                   rsp_led_on,
   input logic                                   rsp_zero_sample
);

   import luxmat_pkg::*;

   `LUXMAT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_lux_value) && $stable(rsp_window_average) &&
      $stable(rsp_led_on) && $stable(rsp_zero_sample),
      "result changed while stalled")

   `LUXMAT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
      "second transaction accepted while busy")

   `LUXMAT_ASSERT_NOW(a_zero_saturates, rsp_valid && rsp_zero_sample,
      rsp_lux_value == LUX_W'(LUX_SATURATED), "zero sample not saturated")

   `LUXMAT_ASSERT_NOW(a_lux_range, rsp_valid,
      rsp_lux_value >= LUX_W'(LUX_MIN) && rsp_lux_value <= LUX_W'(LUX_SATURATED),
      "lux value out of range")

endmodule

bind lux_moving_average_threshold luxmat_checker u_luxmat_checker (.*);

### bench/tb_top.sv
module tb_top;

   localparam int WIN         = luxmat_pkg::DEFAULT_WINDOW_LENGTH;
   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 100;
   localparam int SEG_ITEMS   = 125;

   typedef struct packed {
      logic signed [luxmat_pkg::LUX_W-1:0] lux;
      logic signed [luxmat_pkg::LUX_W-1:0] avg;
      logic                                led;
      logic                                zero;
   } lux_result_type;

   typedef struct {
      logic [luxmat_pkg::SAMPLE_W-1:0] sample;
      bit                              set_thr;
      int                              thr;
      bit                              typed;
      lux_result_type                  want;
   } stim_row_type;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_stall;
   logic        [luxmat_pkg::SAMPLE_W-1:0] req_sensor_sample;
   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic signed [luxmat_pkg::LUX_W-1:0]    rsp_lux_value;
   logic signed [luxmat_pkg::LUX_W-1:0]    rsp_window_average;
   logic                                   rsp_led_on;
   logic                                   rsp_zero_sample;
   logic                                   csr_valid;
   logic                                   csr_ready;
   logic signed [luxmat_pkg::LUX_W-1:0]    csr_light_threshold;

   // model of the filter state
   int             lux_window [WIN] = '{default: 0};
   int             window_total     = 0;
   int             oldest_slot      = 0;
   int             threshold_now    = luxmat_pkg::THRESHOLD_RESET;
   lux_result_type pending_lux_q [$];

   logic           offer_typed;
   lux_result_type offer_want;
   int             send_idle_pct;
   int             rsp_stall_pct;
   int             stall_hold_cycles;
   int             fail_count;
   int             quiet_cycles;

   stim_row_type dir_rows [19] = '{
      '{12'd0,    1'b0, 0,    1'b1, '{17'sd51150, 17'sd3196, 1'b1, 1'b1}},
      '{12'd1,    1'b0, 0,    1'b1, '{17'sd51150, 17'sd6393, 1'b1, 1'b0}},
      '{12'd4095, 1'b0, 0,    1'b1, '{-17'sd37,   17'sd6391, 1'b1, 1'b0}},
      // sum 102263 sits just above 16 * 6391: led on while 6391 is reported
      '{12'd1024, 1'b1, 6391, 1'b1, '{17'sd0,     17'sd6391, 1'b1, 1'b0}},
      '{12'd1024, 1'b1, 6392, 1'b1, '{17'sd0,     17'sd6391, 1'b0, 1'b0}},
      '{12'd1023, 1'b0, 0,    1'b0, '0},
      '{12'd1025, 1'b0, 0,    1'b0, '0},
      '{12'd2,    1'b0, 0,    1'b0, '0},
      '{12'd3,    1'b0, 0,    1'b0, '0},
      '{12'd4094, 1'b0, 0,    1'b0, '0},
      '{12'h555,  1'b1, -64,  1'b0, '0},
      '{12'hAAA,  1'b0, 0,    1'b0, '0},
      '{12'h800,  1'b0, 0,    1'b0, '0},
      '{12'h7FF,  1'b0, 0,    1'b0, '0},
      '{12'd2048, 1'b0, 0,    1'b0, '0},
      '{12'd100,  1'b0, 0,    1'b0, '0},
      '{12'd0,    1'b0, 0,    1'b0, '0},
      '{12'd4095, 1'b0, 0,    1'b0, '0},
      '{12'd4095, 1'b0, 0,    1'b0, '0}
   };

   lux_moving_average_threshold #(
      .WINDOW_LENGTH(WIN)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sensor_sample  (req_sensor_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_lux_value      (rsp_lux_value),
      .rsp_window_average (rsp_window_average),
      .rsp_led_on         (rsp_led_on),
      .rsp_zero_sample    (rsp_zero_sample),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_light_threshold(csr_light_threshold)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Convert one sample, slide the window and return the expected result.
   function automatic lux_result_type advance_lux_window(
      input logic [luxmat_pkg::SAMPLE_W-1:0] smp);
      int             s;
      int             lux;
      int             avg;
      lux_result_type r;
      s = int'(smp);
      if (s == 0) begin
         lux = luxmat_pkg::LUX_SATURATED;
      end else begin
         lux = (luxmat_pkg::LUX_BASE - luxmat_pkg::LUX_SLOPE * s) / s;
      end
      window_total            = window_total - lux_window[oldest_slot] + lux;
      lux_window[oldest_slot] = lux;
      oldest_slot             = (oldest_slot + 1) % WIN;
      avg    = window_total / WIN;
      r.lux  = lux[luxmat_pkg::LUX_W-1:0];
      r.avg  = avg[luxmat_pkg::LUX_W-1:0];
      r.led  = window_total > threshold_now * WIN;
      r.zero = (s == 0);
      return r;
   endfunction

   function automatic logic [luxmat_pkg::SAMPLE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 8) begin
         return '0;
      end else if (r < 30) begin
         return luxmat_pkg::SAMPLE_W'($urandom_range(64, 1));
      end else if (r < 45) begin
         // around the sign change of the lux value
         return luxmat_pkg::SAMPLE_W'($urandom_range(1100, 900));
      end else begin
         return luxmat_pkg::SAMPLE_W'($urandom_range(4095, 0));
      end
   endfunction

   task automatic offer_sample(input logic [luxmat_pkg::SAMPLE_W-1:0] smp,
                               input logic typed, input lux_result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sensor_sample <= smp;
      offer_typed       <= typed;
      offer_want        <= want;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
   endtask

   // Hold the input low until every pending result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_lux_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(input int value);
      csr_light_threshold <= value[luxmat_pkg::LUX_W-1:0];
      csr_valid           <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stall, or a counted hold-off when requested
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            stall_hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      lux_result_type pred;
      lux_result_type front;
      if (!reset) begin
         // compare before push so a same-edge acceptance never matches itself
         if (rsp_valid && !rsp_stall) begin
            if (pending_lux_q.size() == 0) begin
               $error("rsp: result transaction with no expected result pending");
               fail_count++;
            end else begin
               front = pending_lux_q.pop_front();
               if (rsp_lux_value !== front.lux) begin
                  $error("lux_value: expected %0d, actual %0d", front.lux, rsp_lux_value);
                  fail_count++;
               end
               if (rsp_window_average !== front.avg) begin
                  $error("window_average: expected %0d, actual %0d",
                         front.avg, rsp_window_average);
                  fail_count++;
               end
               if (rsp_led_on !== front.led) begin
                  $error("led_on: expected %0d, actual %0d", front.led, rsp_led_on);
                  fail_count++;
               end
               if (rsp_zero_sample !== front.zero) begin
                  $error("zero_sample: expected %0d, actual %0d",
                         front.zero, rsp_zero_sample);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pred = advance_lux_window(req_sensor_sample);
            pending_lux_q.push_back(offer_typed ? offer_want : pred);
         end
         if (csr_valid && csr_ready) begin
            threshold_now = int'(csr_light_threshold);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int seg;
      int n;
      int thr;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_sensor_sample   = '0;
      csr_valid           = 1'b0;
      csr_light_threshold = '0;
      offer_typed         = 1'b0;
      offer_want          = '0;
      send_idle_pct       = 19;
      rsp_stall_pct       = 79;
      stall_hold_cycles   = 0;
      fail_count          = 0;
      quiet_cycles        = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset threshold first
      foreach (dir_rows[i]) begin
         if (dir_rows[i].set_thr) begin
            wait_drained();
            write_threshold(dir_rows[i].thr);
         end
         offer_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);
      end

      for (seg = 0; seg < 6; seg++) begin
         case (seg)
            0: thr = -65536;
            1: thr = 65535;
            2: thr = -64;
            3: thr = $urandom_range(4000, 0);
            4: thr = 0;
            default: thr = $urandom_range(131071, 0);
         endcase
         if (seg < 2) begin
            send_idle_pct = 19;
            rsp_stall_pct = 79;
         end else if (seg < 4) begin
            send_idle_pct = 79;
            rsp_stall_pct = 19;
         end else begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         wait_drained();
         write_threshold(thr);
         for (n = 0; n < SEG_ITEMS; n++) begin
            // long output hold-off while samples keep coming
            if (seg == 1 && n == 40) stall_hold_cycles = 300;
            if (seg == 3 && n == 60) wait_drained();
            offer_sample(pick_sample(), 1'b0, '0);
         end
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && pending_lux_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
